// File: rtl/teei_pkg.sv
// Shared types and codes for the texture edge-extend index unit.
// No dependencies.
package teei_pkg;

    // Fill mode codes on the result channel
    typedef enum logic [1:0] {
        FILL_NONE   = 2'd0,
        FILL_CLAMP  = 2'd1,
        FILL_WRAP   = 2'd2,
        FILL_MIRROR = 2'd3
    } fill_mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_LOADED_SIZE    = 3'd0,
        CFG_REQUESTED_SIZE = 3'd1,
        CFG_ALLOCATED_SIZE = 3'd2,
        CFG_MASK_BITS      = 3'd3,
        CFG_MIRROR_ON      = 3'd4,
        CFG_CLAMP_ON       = 3'd5,
        CFG_AXIS_IS_T      = 3'd6
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int MASK_BITS_W = 4;
    // Width that holds 2^(mask_bits+1) for every 4-bit mask_bits
    localparam int MW = 17;

    // Mode flags from the register file
    typedef struct packed {
        logic [MASK_BITS_W-1:0] mask_bits;
        logic                   mirror_on;
        logic                   clamp_on;
        logic                   axis_is_t;
    } mode_cfg_t;

endpackage

// File: rtl/texture_edge_extend_index_unit.sv
// Top level of the texture edge-extend index unit: input register,
// index calculation, result register. Depends on teei_pkg and submodules.
//
// Channel | Handshake               | Payload
// --------+-------------------------+----------------------------------
// cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
// in      | in_valid / in_ready     | position
// out     | out_valid / out_ready   | fill_mode, source_position
//
// One position per cycle sustained while out_ready stays high; between an input
// transaction and out_valid lie the input register, then the result register,
// and the result transaction waits for out_ready.
// Reset clears the configuration registers to zero and empties both stages.
// A stalled result holds the result register; the input register still
// takes a new position until it too is full, then in_ready drops.
// cfg_ready is always high; write configuration only while idle.
module texture_edge_extend_index_unit #(
    parameter int SIZE_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [teei_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [SIZE_BITS:0]               cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [SIZE_BITS-1:0]             position,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       fill_mode,
    output logic [SIZE_BITS:0]               source_position
);

    logic [SIZE_BITS:0]   loaded_size, requested_size, allocated_size;
    teei_pkg::mode_cfg_t  mode_cfg;
    logic                 s1_valid_reg, s1_valid_next;
    logic [SIZE_BITS-1:0] pos_reg;
    logic                 s1_adv, in_xfer, out_can_load;
    teei_pkg::fill_mode_t calc_mode, out_mode;
    logic [SIZE_BITS:0]   calc_src;

    assign cfg_ready = 1'b1;

    teei_cfg_regs #(.SIZE_BITS(SIZE_BITS)) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (cfg_valid),
        .wr_index       (cfg_index),
        .wr_data        (cfg_data),
        .loaded_size    (loaded_size),
        .requested_size (requested_size),
        .allocated_size (allocated_size),
        .mode_cfg       (mode_cfg)
    );

    // Input stage control
    assign s1_adv   = s1_valid_reg && out_can_load;
    assign in_ready = !s1_valid_reg || out_can_load;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            pos_reg <= position;
    end

    teei_index_calc #(.SIZE_BITS(SIZE_BITS)) u_calc (
        .position        (pos_reg),
        .loaded_size     (loaded_size),
        .requested_size  (requested_size),
        .allocated_size  (allocated_size),
        .mode_cfg        (mode_cfg),
        .fill_mode       (calc_mode),
        .source_position (calc_src)
    );

    teei_out_stage #(.SIZE_BITS(SIZE_BITS)) u_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (s1_adv),
        .fill_mode_in    (calc_mode),
        .source_in       (calc_src),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .can_load        (out_can_load),
        .fill_mode       (out_mode),
        .source_position (source_position)
    );

    assign fill_mode = out_mode;

endmodule

// File: rtl/teei_cfg_regs.sv
// Configuration register file for the edge-extend index unit.
// Depends on teei_pkg.
module teei_cfg_regs #(
    parameter int SIZE_BITS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [teei_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [SIZE_BITS:0]               wr_data,
    output logic [SIZE_BITS:0]               loaded_size,
    output logic [SIZE_BITS:0]               requested_size,
    output logic [SIZE_BITS:0]               allocated_size,
    output teei_pkg::mode_cfg_t              mode_cfg
);

    logic [SIZE_BITS:0]  loaded_reg;
    logic [SIZE_BITS:0]  requested_reg;
    logic [SIZE_BITS:0]  allocated_reg;
    teei_pkg::mode_cfg_t mode_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            requested_reg <= '0;
            allocated_reg <= '0;
            mode_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                teei_pkg::CFG_LOADED_SIZE:    loaded_reg    <= wr_data;
                teei_pkg::CFG_REQUESTED_SIZE: requested_reg <= wr_data;
                teei_pkg::CFG_ALLOCATED_SIZE: allocated_reg <= wr_data;
                teei_pkg::CFG_MASK_BITS:
                    mode_reg.mask_bits <= wr_data[teei_pkg::MASK_BITS_W-1:0];
                teei_pkg::CFG_MIRROR_ON:      mode_reg.mirror_on <= wr_data[0];
                teei_pkg::CFG_CLAMP_ON:       mode_reg.clamp_on  <= wr_data[0];
                teei_pkg::CFG_AXIS_IS_T:      mode_reg.axis_is_t <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign loaded_size    = loaded_reg;
    assign requested_size = requested_reg;
    assign allocated_size = allocated_reg;
    assign mode_cfg       = mode_reg;

endmodule

// File: rtl/teei_index_calc.sv
// Combinational fill-mode decision and source position for one texel.
// Depends on teei_pkg.
module teei_index_calc #(
    parameter int SIZE_BITS = 10
) (
    input  logic [SIZE_BITS-1:0]  position,
    input  logic [SIZE_BITS:0]    loaded_size,
    input  logic [SIZE_BITS:0]    requested_size,
    input  logic [SIZE_BITS:0]    allocated_size,
    input  teei_pkg::mode_cfg_t   mode_cfg,
    output teei_pkg::fill_mode_t  fill_mode,
    output logic [SIZE_BITS:0]    source_position
);

    localparam int MW = teei_pkg::MW;
    localparam int SW = SIZE_BITS + 1;

    logic [MW-1:0] p, ls, rs, as, es;
    logic [MW-1:0] w, m, m2, pm, pn, pm1;
    logic [MW-1:0] wrap_end, wrap_val, mirror_val;
    logic          in_la, in_le, in_ea;

    // Widen everything for compares against the period
    assign p  = MW'(position);
    assign ls = MW'(loaded_size);
    assign rs = MW'(requested_size);
    assign as = MW'(allocated_size);
    assign es = mode_cfg.clamp_on ? rs : as;

    assign w   = MW'(1) << mode_cfg.mask_bits;
    assign m   = w - MW'(1);
    assign m2  = (w << 1) - MW'(1);
    assign pm  = p & m;
    assign pn  = p & m2;
    assign pm1 = p & m;

    assign in_la = (p >= ls) && (p < as);
    assign in_le = (p >= ls) && (p < es);
    assign in_ea = (p >= es) && (p < as);

    // Wrap and mirror sources: S and T axes wrap differently; range end is e in the repeat case
    always_comb
    begin
        wrap_end = (ls == w) ? es : as;
        if (mode_cfg.axis_is_t)
            wrap_val = (p > m) ? pm : (p - ls);
        else
            wrap_val = (pm < ls) ? pm : (wrap_end - pm);
        mirror_val = (pn <= m) ? pm1 : (m2 - pn);
    end

    // Decision tree on sizes and period
    always_comb
    begin
        fill_mode       = teei_pkg::FILL_NONE;
        source_position = '0;
        if (ls >= as)
        begin
            fill_mode = teei_pkg::FILL_NONE;
        end
        else if (mode_cfg.mask_bits == '0)
        begin
            if (ls != '0 && in_la)
            begin
                fill_mode       = teei_pkg::FILL_CLAMP;
                source_position = SW'(ls - MW'(1));
            end
        end
        else if (ls == w)
        begin
            if (es < as && es != '0 && in_ea)
            begin
                fill_mode       = teei_pkg::FILL_CLAMP;
                source_position = SW'(es - MW'(1));
            end
            else if (in_le)
            begin
                if (mode_cfg.mirror_on)
                begin
                    fill_mode       = teei_pkg::FILL_MIRROR;
                    source_position = SW'(mirror_val);
                end
                else
                begin
                    fill_mode       = teei_pkg::FILL_WRAP;
                    source_position = SW'(wrap_val);
                end
            end
        end
        else if (ls < rs && rs == w && w == as)
        begin
            if (in_la)
            begin
                fill_mode       = teei_pkg::FILL_WRAP;
                source_position = SW'(wrap_val);
            end
        end
        else if (ls <= rs && rs < w)
        begin
            if (ls != '0 && in_la)
            begin
                fill_mode       = teei_pkg::FILL_CLAMP;
                source_position = SW'(ls - MW'(1));
            end
        end
    end

endmodule

// File: rtl/teei_out_stage.sv
// Result register with valid/ready handshake toward the consumer.
// Depends on teei_pkg.
module teei_out_stage #(
    parameter int SIZE_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  teei_pkg::fill_mode_t fill_mode_in,
    input  logic [SIZE_BITS:0]   source_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 can_load,
    output teei_pkg::fill_mode_t fill_mode,
    output logic [SIZE_BITS:0]   source_position
);

    logic                 valid_reg, valid_next;
    teei_pkg::fill_mode_t mode_reg;
    logic [SIZE_BITS:0]   src_reg;

    // Free when empty or being drained this cycle
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg <= fill_mode_in;
            src_reg  <= source_in;
        end
    end

    assign out_valid       = valid_reg;
    assign fill_mode       = mode_reg;
    assign source_position = src_reg;

endmodule

// File: rtl/teei_checker.sv
// Port-level checker for the texture edge-extend index unit, with bind.
// Depends on teei_pkg and texture_edge_extend_index_unit.
module teei_checker #(
    parameter int SIZE_BITS = 10
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           fill_mode,
    input logic [SIZE_BITS:0]   source_position
);

    // A pending result stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    // Positions left as is always report source zero
    a_none_src_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fill_mode == teei_pkg::FILL_NONE |-> source_position == '0)
        else $error("nonzero source with no fill");

    // Input backpressure only when both stages hold data and output stalls
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A fresh result follows an input transaction through the input and result registers
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without matching input transaction");

endmodule

bind texture_edge_extend_index_unit teei_checker #(.SIZE_BITS(SIZE_BITS)) u_teei_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fill_mode       (fill_mode),
    .source_position (source_position)
);

// File: tb/sv/tb.sv
// Testbench for texture_edge_extend_index_unit: directed and random positions over
// many axis settings, checked against a built-in fill predictor.
// Depends on teei_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;

    localparam int SIZE_BITS       = 10;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 30;
    localparam int ITEMS_PER_PHASE = 30;
    localparam logic [teei_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    // One expected result
    typedef struct {
        teei_pkg::fill_mode_t  mode;
        logic [SIZE_BITS:0]    src;
        logic [SIZE_BITS-1:0]  pos;
    } texel_fill_t;

    // Predicts the fill of each accepted position and checks the results in order
    class texel_fill_checker;
        logic [SIZE_BITS:0]               loaded_size;
        logic [SIZE_BITS:0]               requested_size;
        logic [SIZE_BITS:0]               allocated_size;
        logic [teei_pkg::MASK_BITS_W-1:0] mask_bits;
        bit                               mirror_on;
        bit                               clamp_on;
        bit                               axis_is_t;
        texel_fill_t                      pending_fills[$];
        int                               error_count;

        function new();
            loaded_size    = '0;
            requested_size = '0;
            allocated_size = '0;
            mask_bits      = '0;
            mirror_on      = 1'b0;
            clamp_on       = 1'b0;
            axis_is_t      = 1'b0;
            error_count    = 0;
        endfunction

        function void write_register(logic [teei_pkg::CFG_INDEX_W-1:0] idx,
                                     logic [SIZE_BITS:0] data);
            case (idx)
                teei_pkg::CFG_LOADED_SIZE:    loaded_size    = data;
                teei_pkg::CFG_REQUESTED_SIZE: requested_size = data;
                teei_pkg::CFG_ALLOCATED_SIZE: allocated_size = data;
                teei_pkg::CFG_MASK_BITS:
                    mask_bits = data[teei_pkg::MASK_BITS_W-1:0];
                teei_pkg::CFG_MIRROR_ON:      mirror_on      = data[0];
                teei_pkg::CFG_CLAMP_ON:       clamp_on       = data[0];
                teei_pkg::CFG_AXIS_IS_T:      axis_is_t      = data[0];
                default: ;
            endcase
        endfunction

        // S and T axes wrap by different formulas
        function int unsigned wrap_source(int unsigned p, int unsigned lo,
                                          int unsigned range_end, int unsigned m);
            if (axis_is_t)
                return (p > m) ? (p & m) : p - lo;
            return ((p & m) < lo) ? (p & m) : range_end - (p & m);
        endfunction

        function texel_fill_t compute_fill(logic [SIZE_BITS-1:0] pos);
            texel_fill_t f;
            int unsigned p, l, r, a, mb, w, m, n, e, s;
            p  = pos;
            l  = loaded_size;
            r  = requested_size;
            a  = allocated_size;
            mb = mask_bits;
            w  = 32'd1 << mb;
            m  = w - 1;
            n  = (w << 1) - 1;
            s  = 0;
            f.mode = teei_pkg::FILL_NONE;
            f.pos  = pos;
            if (l < a)
            begin
                if (mb == 0)
                begin
                    // clamp only
                    if (l > 0 && p >= l && p < a)
                    begin
                        f.mode = teei_pkg::FILL_CLAMP;
                        s = l - 1;
                    end
                end
                else if (l == w)
                begin
                    // repeat up to the range end, then clamp from the last repeated texel
                    e = clamp_on ? r : a;
                    if (e < a && e > 0 && p >= e && p < a)
                    begin
                        f.mode = teei_pkg::FILL_CLAMP;
                        s = e - 1;
                    end
                    else if (p >= l && p < e)
                    begin
                        if (mirror_on)
                        begin
                            f.mode = teei_pkg::FILL_MIRROR;
                            s = ((p & n) <= m) ? (p & m) : n - (p & n);
                        end
                        else
                        begin
                            f.mode = teei_pkg::FILL_WRAP;
                            s = wrap_source(p, l, e, m);
                        end
                    end
                end
                else if (l < r && r == w && w == a)
                begin
                    if (p >= l && p < a)
                    begin
                        f.mode = teei_pkg::FILL_WRAP;
                        s = wrap_source(p, l, a, m);
                    end
                end
                else if (l <= r && r < w)
                begin
                    if (l > 0 && p >= l && p < a)
                    begin
                        f.mode = teei_pkg::FILL_CLAMP;
                        s = l - 1;
                    end
                end
            end
            if (f.mode == teei_pkg::FILL_NONE)
                s = 0;
            f.src = s[SIZE_BITS:0];
            return f;
        endfunction

        function void note_position(logic [SIZE_BITS-1:0] pos);
            pending_fills.push_back(compute_fill(pos));
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            error_count++;
        endtask

        task check_fill(logic [1:0] mode, logic [SIZE_BITS:0] src);
            texel_fill_t exp_fill;
            if (pending_fills.size() == 0)
            begin
                report($sformatf("result mode %0d src %0d with nothing pending", mode, src));
                return;
            end
            exp_fill = pending_fills.pop_front();
            if (mode !== exp_fill.mode)
                report($sformatf("pos %0d: fill_mode %0d, predicted %0d",
                                 exp_fill.pos, mode, exp_fill.mode));
            if (src !== exp_fill.src)
                report($sformatf("pos %0d: source_position %0d, predicted %0d",
                                 exp_fill.pos, src, exp_fill.src));
        endtask

        function int pending();
            return pending_fills.size();
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [teei_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_BITS:0]               cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic [SIZE_BITS-1:0]             position = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [1:0]                       fill_mode;
    logic [SIZE_BITS:0]               source_position;

    texel_fill_checker fills = new();

    // Register values for the next setting, in index order
    logic [SIZE_BITS:0]   cfg_vals [0:6];
    teei_pkg::cfg_index_t reg_order [0:6];
    int                   stall_pct = 0;
    int                   hold_trigger = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;

    texture_edge_extend_index_unit #(
        .SIZE_BITS(SIZE_BITS)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .position        (position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .fill_mode       (fill_mode),
        .source_position (source_position)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Write every register, sometimes also the unused index; block must be idle
    task program_axis(input int unsigned l, input int unsigned r, input int unsigned a,
                      input int unsigned mb, input int unsigned mir, input int unsigned clp,
                      input int unsigned axt, input bit poke_unused);
        int n;
        cfg_vals[0] = l[SIZE_BITS:0];
        cfg_vals[1] = r[SIZE_BITS:0];
        cfg_vals[2] = a[SIZE_BITS:0];
        cfg_vals[3] = mb[SIZE_BITS:0];
        cfg_vals[4] = mir[SIZE_BITS:0];
        cfg_vals[5] = clp[SIZE_BITS:0];
        cfg_vals[6] = axt[SIZE_BITS:0];
        n = poke_unused ? 8 : 7;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            if (i < 7)
            begin
                cfg_index <= reg_order[i];
                cfg_data  <= cfg_vals[i];
            end
            else
            begin
                cfg_index <= CFG_UNUSED_INDEX;
                cfg_data  <= (SIZE_BITS + 1)'($urandom_range(0, 2047));
            end
            do @(posedge clk); while (!cfg_ready);
            fills.write_register(cfg_index, cfg_data);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random setting, weighted toward the wrap and mirror branches
    task program_random();
        int unsigned kind, l, r, a, mb, w;
        kind = $urandom_range(0, 9);
        if (kind <= 1)
        begin
            program_axis($urandom_range(0, 1024), $urandom_range(0, 1024),
                         $urandom_range(0, 1024), $urandom_range(0, 15),
                         $urandom_range(0, 2047), $urandom_range(0, 2047),
                         $urandom_range(0, 2047), $urandom_range(0, 7) == 0);
        end
        else if (kind <= 5)
        begin
            mb = $urandom_range(1, 10);
            l  = 1 << mb;
            a  = l + $urandom_range(1, 1024);
            r  = $urandom_range(0, a);
            program_axis(l, r, a, mb, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), 1'b0);
        end
        else if (kind <= 7)
        begin
            mb = $urandom_range(1, 10);
            w  = 1 << mb;
            program_axis($urandom_range(0, w - 1), w, w, mb, $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        end
        else if (kind == 8)
        begin
            program_axis($urandom_range(0, 1024), $urandom_range(0, 1024),
                         $urandom_range(0, 1024), 0, $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1), 1'b0);
        end
        else
        begin
            mb = $urandom_range(1, 10);
            w  = 1 << mb;
            r  = $urandom_range(0, w - 1);
            program_axis($urandom_range(0, r), r, $urandom_range(0, 1024), mb,
                         $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), 1'b0);
        end
    endtask

    // Offer one position and hold it until the transaction completes
    task send_position(input int unsigned p);
        in_valid <= 1'b1;
        position <= p[SIZE_BITS-1:0];
        do @(posedge clk); while (!in_ready);
        fills.note_position(p[SIZE_BITS-1:0]);
    endtask

    // Stop offering and let every pending result come out
    task drain_block();
        in_valid <= 1'b0;
        while (fills.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: check each transaction, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            fills.check_fill(fill_mode, source_position);
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: too long without any transaction on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int          sender_idle;
        int          gap;
        int unsigned a, p;
        reg_order[0] = teei_pkg::CFG_LOADED_SIZE;
        reg_order[1] = teei_pkg::CFG_REQUESTED_SIZE;
        reg_order[2] = teei_pkg::CFG_ALLOCATED_SIZE;
        reg_order[3] = teei_pkg::CFG_MASK_BITS;
        reg_order[4] = teei_pkg::CFG_MIRROR_ON;
        reg_order[5] = teei_pkg::CFG_CLAMP_ON;
        reg_order[6] = teei_pkg::CFG_AXIS_IS_T;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: loaded not below allocated, nothing filled
        send_position(0);
        send_position(1023);
        drain_block();

        // Clamp only, also from zero
        program_axis(5, 0, 20, 0, 0, 0, 0, 1'b1);
        send_position(4);
        send_position(5);
        send_position(19);
        send_position(20);
        drain_block();
        program_axis(0, 0, 10, 0, 0, 0, 0, 1'b0);
        send_position(3);
        drain_block();

        // Loaded equals period: S wrap, T wrap, mirror
        program_axis(8, 0, 32, 3, 0, 0, 0, 1'b0);
        send_position(8);
        send_position(13);
        send_position(31);
        drain_block();
        program_axis(8, 0, 32, 3, 0, 0, 1, 1'b0);
        send_position(9);
        send_position(31);
        drain_block();
        program_axis(8, 0, 40, 3, 1, 0, 0, 1'b0);
        send_position(12);
        send_position(20);
        send_position(39);
        drain_block();

        // Repeat limited to requested size, then clamp; end below loaded too
        program_axis(16, 24, 40, 4, 0, 1, 0, 1'b0);
        send_position(20);
        send_position(39);
        drain_block();
        program_axis(16, 6, 40, 4, 1, 1, 0, 1'b0);
        send_position(3);
        send_position(10);
        drain_block();

        // Requested equals period equals allocated: wrap, largest size on T
        program_axis(20, 32, 32, 5, 0, 0, 0, 1'b0);
        send_position(25);
        drain_block();
        program_axis(0, 1024, 1024, 10, 0, 0, 1, 1'b0);
        send_position(0);
        send_position(1023);
        drain_block();

        // Requested below period: clamp; widest mask and allocated extremes
        program_axis(10, 30, 100, 6, 0, 0, 0, 1'b0);
        send_position(50);
        drain_block();
        program_axis(3, 5, 2047, 15, 1, 1, 1, 1'b0);
        send_position(1023);
        drain_block();

        // Random settings, rotating through the idling patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            program_random();
            case (ph % 4)
                0:
                begin
                    sender_idle = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    sender_idle = 59;
                    stall_pct <= 0;
                end
                2:
                begin
                    sender_idle = 0;
                    stall_pct <= 59;
                end
                default:
                begin
                    sender_idle = 22;
                    stall_pct <= 22;
                end
            endcase
            // Long result hold-off while positions keep coming
            if (ph == 5 || ph == 18)
            begin
                sender_idle = 0;
                hold_trigger <= hold_trigger + 1;
            end
            a = cfg_vals[2];
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                gap = 0;
                while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle)
                    gap++;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                if (a == 0 || $urandom_range(0, 3) == 0)
                    p = $urandom_range(0, 1023);
                else
                    p = $urandom_range(0, (a > 1024) ? 1023 : a - 1);
                send_position(p);
            end
            drain_block();
        end

        stall_pct <= 0;
        drain_block();
        if (fills.error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
